### sv/minmax_contrast_stretch_top_macros.svh
// Assertion macros shared by the contrast stretch RTL.
`ifndef MINMAX_CONTRAST_STRETCH_TOP_MACROS_SVH
`define MINMAX_CONTRAST_STRETCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("minmax_contrast_stretch: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("minmax_contrast_stretch: check failed");

`endif

### sv/mcs_pkg.sv
// Types and constants for the min-max contrast stretch block.
`default_nettype none

package mcs_pkg;

    localparam int IDX_W     = 12;
    localparam int PIX_W     = 32;
    localparam int GOAL_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [GOAL_W-1:0] PIX_MAX = 8'd255;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNLOADED = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_HIGH = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] pixel_value;
        logic               last;
        logic [IDX_W-1:0]   index;
    } t_in;

    typedef struct packed {
        logic [GOAL_W-1:0] scaled_value;
        logic              status;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

### sv/mcs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

`include "minmax_contrast_stretch_top_macros.svh"

module mcs_div
    import mcs_pkg::*;
#(
    parameter int NW = 41,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [NW-1:0]      o_quotient,
    output logic [DW-1:0]      o_remainder
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_fit;

    // Shift the next dividend bit into the partial remainder, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_fit   = (w_trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `MCS_ASSERT_SAME(a_div_no_restart, i_start, !r_busy)
    `MCS_ASSERT_NEXT(a_div_done_after_last, r_busy && (r_cnt == CNTW'(1)), r_done && !r_busy)
    `MCS_ASSERT_SAME(a_div_rem_below, r_done && (i_divisor != '0), r_rem < i_divisor)

endmodule

`default_nettype wire

### sv/mcs_round.sv
// Round-to-nearest-even of the quotient, offset by the low goal, saturated to 8 bits.
`default_nettype none

module mcs_round
    import mcs_pkg::*;
#(
    parameter int NW = 41,
    parameter int DW = 32
) (
    input  wire logic [NW-1:0]     i_quotient,
    input  wire logic [DW-1:0]     i_remainder,
    input  wire logic [DW-1:0]     i_divisor,
    input  wire logic              i_neg,
    input  wire logic [GOAL_W-1:0] i_goal_low,
    output logic [GOAL_W-1:0]      o_value
);

    localparam int RW = NW + 3;

    logic [DW:0]          w_twice;
    logic [DW:0]          w_div_x;
    logic                 w_up;
    logic [NW:0]          w_q_rnd;
    logic signed [RW-1:0] w_q_s;
    logic signed [RW-1:0] w_goal_s;
    logic signed [RW-1:0] w_res;
    logic signed [RW-1:0] w_max_s;

    always_comb begin
        w_twice  = {i_remainder, 1'b0};
        w_div_x  = {1'b0, i_divisor};
        // Round up past the half, and on an exact half only toward an even quotient.
        w_up     = (w_twice > w_div_x) || ((w_twice == w_div_x) && i_quotient[0]);
        w_q_rnd  = {1'b0, i_quotient} + (NW + 1)'(w_up);
        w_q_s    = signed'(RW'(w_q_rnd));
        w_goal_s = signed'(RW'(i_goal_low));
        w_max_s  = signed'(RW'(PIX_MAX));
        w_res    = i_neg ? (w_goal_s - w_q_s) : (w_goal_s + w_q_s);
        priority if (w_res < 0) begin
            o_value = '0;
        end else if (w_res > w_max_s) begin
            o_value = PIX_MAX;
        end else begin
            o_value = w_res[GOAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/minmax_contrast_stretch_top.sv
// Load item: it is taken on the transfer edge and the next item follows at once.
// Read item: the sequencer steps through multiply, divider start, divide and finish,
// the bit-serial divider giving one of its SAMPLE_BITS + 9 quotient bits a cycle.
// Unloaded index or flat frame: the divider is skipped.
// One read at a time; the result register lets the next item in while a result waits.
// Synchronous active-low reset clears control, count, min/max and goals; the store is not cleared.
`default_nettype none

`include "minmax_contrast_stretch_top_macros.svh"

module minmax_contrast_stretch_top
    import mcs_pkg::*;
#(
    parameter int MAX_PIXELS  = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input item channel
    input  wire logic                 i_in_valid,
    input  wire t_in                  i_in_data,
    output logic                      o_in_stall,
    // result channel
    output logic                      o_out_valid,
    output t_out                      o_out_data,
    input  wire logic                 i_out_stall,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [GOAL_W-1:0]    i_cfg_wdata
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int XW  = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW  = (SB > PIX_W) ? SB : PIX_W;
    localparam int NW  = SB + 9;          // |diff| * |span| fits SB+1 plus 8 bits
    localparam int DFW = SB + 1;

    // Sample range limits, at the extended compare width and at storage width.
    localparam logic signed [EW-1:0] EXT_SMAX = {{(EW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [EW-1:0] EXT_SMIN = ~EXT_SMAX;
    localparam logic signed [SB-1:0] SMAX     = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN     = {1'b1, {(SB - 1){1'b0}}};

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                r_state;
    t_state                n_state;

    logic [SB-1:0]         mem [MAX_PIXELS];
    logic signed [SB-1:0]  r_rd_data;

    logic signed [SB-1:0]  r_min;
    logic signed [SB-1:0]  r_max;
    logic [CW-1:0]         r_count;
    logic                  r_closed;

    logic [GOAL_W-1:0]     r_goal_low;
    logic [GOAL_W-1:0]     r_goal_high;

    logic                  r_bad;
    logic                  r_flat;
    logic [SB-1:0]         r_d;
    logic [NW-1:0]         r_prod;
    logic                  r_neg;

    logic                  r_out_valid;
    t_out                  r_out;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic                  w_idle;
    logic                  w_in_xfer;
    logic                  w_load;
    logic                  w_read;
    logic                  w_out_free;
    logic                  w_div_start;
    logic                  w_out_load;

    logic signed [EW-1:0]  w_ext;
    logic signed [EW-1:0]  w_sat;
    logic signed [SB-1:0]  w_sample;
    logic [CW-1:0]         w_eff_cnt;
    logic signed [SB-1:0]  w_eff_min;
    logic signed [SB-1:0]  w_eff_max;
    logic                  w_room;

    logic [XW-1:0]         w_idx_x;
    logic [XW-1:0]         w_cnt_x;
    logic                  w_bad;
    logic                  w_flat;
    logic [DFW-1:0]        w_range;

    logic signed [DFW-1:0] w_diff;
    logic [DFW-1:0]        w_diff_mag;
    logic signed [GOAL_W:0] w_span;
    logic [GOAL_W-1:0]     w_span_mag;
    logic [NW-1:0]         w_prod;

    logic                  w_div_done;
    logic [NW-1:0]         w_quo;
    logic [SB-1:0]         w_rem;
    logic [GOAL_W-1:0]     w_rounded;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_load     = w_in_xfer && (i_in_data.cmd == CMD_LOAD);
    assign w_read     = w_in_xfer && (i_in_data.cmd == CMD_READ);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Load path: saturate, start a new frame if the last one was closed,
    // write the store while there is room, track min and max.
    // ------------------------------------------------------------------
    always_comb begin
        w_ext = EW'(i_in_data.pixel_value);
        priority if (w_ext > EXT_SMAX) begin
            w_sat = EXT_SMAX;
        end else if (w_ext < EXT_SMIN) begin
            w_sat = EXT_SMIN;
        end else begin
            w_sat = w_ext;
        end
        w_sample  = w_sat[SB-1:0];
        w_eff_cnt = r_closed ? '0   : r_count;
        w_eff_min = r_closed ? SMAX : r_min;
        w_eff_max = r_closed ? SMIN : r_max;
        w_room    = (w_eff_cnt < CW'(MAX_PIXELS));
    end

    // Read path decode: unloaded index and flat frame skip the divider.
    always_comb begin
        w_idx_x = XW'(i_in_data.index);
        w_cnt_x = XW'(r_count);
        w_bad   = (w_idx_x >= w_cnt_x);
        w_flat  = (r_max <= r_min);
        w_range = {r_max[SB-1], r_max} - {r_min[SB-1], r_min};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= SMAX;
            r_max    <= SMIN;
            r_count  <= '0;
            r_closed <= 1'b1;
        end else if (w_load) begin
            r_closed <= i_in_data.last;
            if (w_room) begin
                r_count <= w_eff_cnt + 1'b1;
                r_min   <= (w_sample < w_eff_min) ? w_sample : w_eff_min;
                r_max   <= (w_sample > w_eff_max) ? w_sample : w_eff_max;
            end else begin
                r_count <= w_eff_cnt;
                r_min   <= w_eff_min;
                r_max   <= w_eff_max;
            end
        end
    end

    // Frame store: one write port for loads, one registered read port for reads.
    always_ff @(posedge i_clk) begin
        if (w_load && w_room) begin
            mem[AW'(w_eff_cnt)] <= w_sample;
        end
        if (w_read) begin
            r_rd_data <= mem[AW'(w_idx_x)];
        end
    end

    // Goal registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_low  <= '0;
            r_goal_high <= PIX_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GOAL_LOW:  r_goal_low  <= i_cfg_wdata;
                REG_GOAL_HIGH: r_goal_high <= i_cfg_wdata;
            endcase
        end
    end

    // Capture the read's case flags and divisor; min/max hold during the read.
    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_bad  <= w_bad;
            r_flat <= w_flat;
            r_d    <= w_range[SB-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Numerator: (v - min) * (goal_high - goal_low), sign and magnitude.
    // ------------------------------------------------------------------
    always_comb begin
        w_diff     = {r_rd_data[SB-1], r_rd_data} - {r_min[SB-1], r_min};
        w_diff_mag = w_diff[DFW-1] ? DFW'(-w_diff) : DFW'(w_diff);
        w_span     = signed'({1'b0, r_goal_high}) - signed'({1'b0, r_goal_low});
        w_span_mag = w_span[GOAL_W] ? GOAL_W'(-w_span) : GOAL_W'(w_span);
        // Full-width product: the result is exactly as wide as both factors together.
        w_prod     = w_diff_mag * w_span_mag;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
            r_neg  <= w_diff[DFW-1] ^ w_span[GOAL_W];
        end
    end

    mcs_div #(
        .NW (NW),
        .DW (SB)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_prod),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    mcs_round #(
        .NW (NW),
        .DW (SB)
    ) u_round (
        .i_quotient  (w_quo),
        .i_remainder (w_rem),
        .i_divisor   (r_d),
        .i_neg       (r_neg),
        .i_goal_low  (r_goal_low),
        .o_value     (w_rounded)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_read) begin
                    n_state = (w_bad || w_flat) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_idle      = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:  w_idle      = 1'b1;
            ST_MUL:   ;
            ST_START: w_div_start = 1'b1;
            ST_DIV:   ;
            ST_FIN:   w_out_load  = w_out_free;
            default:  ;
        endcase
    end

    assign o_in_stall = !w_idle;

    // ------------------------------------------------------------------
    // Result register: hold while stalled, drop valid once transferred.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            priority if (r_bad) begin
                r_out.scaled_value <= '0;
                r_out.status       <= STATUS_UNLOADED;
            end else if (r_flat) begin
                r_out.scaled_value <= r_goal_low;
                r_out.status       <= STATUS_OK;
            end else begin
                r_out.scaled_value <= w_rounded;
                r_out.status       <= STATUS_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MCS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(MAX_PIXELS))
    `MCS_ASSERT_SAME(a_min_le_max, r_count != '0, r_min <= r_max)
    `MCS_ASSERT_SAME(a_div_nonzero, (r_state == ST_START) || (r_state == ST_DIV), r_d != '0)
    `MCS_ASSERT_NEXT(a_unloaded_status, w_out_load && r_bad,
                     o_out_valid && (o_out_data.status == STATUS_UNLOADED))

endmodule

`default_nettype wire
